// ===== design/ps2kr_pkg.sv =====
// package for the ps2 key receiver and classifier
// holds the configuration, queue item and classifier types and fixed codes
// no dependencies
package ps2kr_pkg;

   localparam logic [4:0] LAST_WAIT      = 5'd22;
   localparam logic [7:0] RELEASE_PREFIX = 8'hf0;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [1:0] {
      CSR_TIMEOUT_TICKS      = 2'd0,
      CSR_HOLD_TICKS         = 2'd1,
      CSR_LONG_PRESS_REPEATS = 2'd2,
      CSR_IDLE_LIMIT         = 2'd3
   } csr_index_type;

   localparam logic [15:0] TIMEOUT_RESET = 16'd10000;
   localparam logic [15:0] HOLD_RESET    = 16'd1000;
   localparam logic [7:0]  REPEATS_RESET = 8'd3;
   localparam logic [7:0]  IDLE_RESET    = 8'd50;

   typedef enum logic [1:0] {
      MODE_NONE       = 2'd0,
      MODE_PRESS      = 2'd1,
      MODE_LONG_BEGUN = 2'd2,
      MODE_LONG_HELD  = 2'd3
   } press_mode_type;

   typedef enum logic [2:0] {
      CLS_IDLE    = 3'b001,
      CLS_PRESSED = 3'b010,
      CLS_LONG    = 3'b100
   } class_state_type;

   typedef struct packed {
      logic [15:0] timeout_ticks;
      logic [15:0] hold_ticks;
      logic [7:0]  long_press_repeats;
      logic [7:0]  idle_limit;
   } cfg_type;

   typedef struct packed {
      logic       clock_drive_low;
      logic       byte_valid;
      logic [7:0] key_byte;
   } frame_result_type;

endpackage

// ===== design/ps2_key_receiver_classifier_unit.sv =====
// top level of the ps2 key receiver and classifier
// uses ps2kr_pkg, ps2kr_front, ps2kr_queue and ps2kr_back
//
// channel  direction  fields
// req      in         clock_level, data_level
// rsp      out        clock_drive_low, byte_valid, key_byte, press_mode, held_code
// csr      in         timeout_ticks, hold_ticks, long_press_repeats, idle_limit
//
// one item per cycle sustained while the rsp side does not stall; an item's result is written to
// the output register when the classifier takes it, after passing through the queue
// the frame receiver works out an item combinationally; the classifier updates its state as it takes one
// reset clears the control state and loads the register defaults; queue entries and result data are not reset
// a stalled rsp side fills the queue of QUEUE_DEPTH items, then req_tready drops
module ps2_key_receiver_classifier_unit
   import ps2kr_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [0] clock_level, [1] data_level
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] clock_drive_low, [1] byte_valid, [9:2] key_byte, [11:10] press_mode,
   // [19:12] held_code
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [1:0]            csr_addr,
   input  logic [15:0]           csr_wdata
);

   cfg_type          cfg_ff;
   logic             push_valid, push_ready;
   frame_result_type push_item;
   logic             pop_valid, pop_ready;
   frame_result_type pop_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks      <= TIMEOUT_RESET;
         cfg_ff.hold_ticks         <= HOLD_RESET;
         cfg_ff.long_press_repeats <= REPEATS_RESET;
         cfg_ff.idle_limit         <= IDLE_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_TIMEOUT_TICKS:      cfg_ff.timeout_ticks      <= csr_wdata;
            CSR_HOLD_TICKS:         cfg_ff.hold_ticks         <= csr_wdata;
            CSR_LONG_PRESS_REPEATS: cfg_ff.long_press_repeats <= csr_wdata[7:0];
            CSR_IDLE_LIMIT:         cfg_ff.idle_limit         <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   ps2kr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .sample_valid (req_tvalid),
      .clock_level  (req_tdata[0]),
      .data_level   (req_tdata[1]),
      .push_ready   (push_ready),
      .push_valid   (push_valid),
      .push_item    (push_item)
   );

   ps2kr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   ps2kr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   assign req_tready = push_ready;

   a_no_byte_while_driving: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("result drives the clock and reports a byte at once");

   a_zero_byte_when_none: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[1]) |-> (rsp_tdata[9:2] == 8'd0))
      else $error("nonzero key byte without a finished attempt");

   a_queue_entry_clean: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !(push_item.clock_drive_low && push_item.byte_valid))
      else $error("frame receiver ends an attempt during the hold phase");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

// ===== design/ps2kr_front.sv =====
// frame receiver: follows one ps2 frame per attempt and the hold phase between attempts
// uses ps2kr_pkg; feeds ps2kr_queue
module ps2kr_front
   import ps2kr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             sample_valid,
   input  logic             clock_level,
   input  logic             data_level,
   input  logic             push_ready,
   output logic             push_valid,
   output frame_result_type push_item
);

   logic [4:0]  step_ff, step_in;
   logic [15:0] wait_ff, wait_in;
   logic [15:0] hold_ff, hold_in;
   logic [7:0]  shift_ff, shift_in;

   logic        in_hold;
   logic        drive;
   logic        ended;
   logic [7:0]  byte_out;
   logic [4:0]  eff_step;
   logic [15:0] eff_wait;
   logic [4:0]  idx;
   logic        want_low;
   logic        met;
   logic        accept;

   assign in_hold = (step_ff == 5'd0) || (step_ff > LAST_WAIT);
   assign accept  = sample_valid && push_ready;

   always_comb begin
      step_in  = step_ff;
      wait_in  = wait_ff;
      hold_in  = hold_ff;
      shift_in = shift_ff;
      drive    = 1'b0;
      ended    = 1'b0;
      byte_out = 8'd0;
      eff_step = step_ff;
      eff_wait = wait_ff;
      idx      = 5'd0;
      want_low = 1'b0;
      met      = 1'b0;
      if (in_hold) begin
         if (hold_ff < cfg.hold_ticks) begin
            hold_in = hold_ff + 16'd1;
            drive   = 1'b1;
         end else begin
            hold_in  = 16'd0;
            eff_step = 5'd1;
            eff_wait = cfg.timeout_ticks;
            step_in  = 5'd1;
            wait_in  = cfg.timeout_ticks;
         end
      end
      if (!drive) begin
         idx      = eff_step - 5'd1;
         want_low = !idx[0];
         met      = want_low ? !clock_level : clock_level;
         if (met) begin
            if (want_low && idx >= 5'd2 && idx <= 5'd16) begin
               shift_in = {data_level, shift_ff[7:1]};
            end
            if (eff_step >= LAST_WAIT) begin
               ended    = 1'b1;
               byte_out = shift_in;
            end else begin
               step_in = eff_step + 5'd1;
               wait_in = cfg.timeout_ticks;
            end
         end else if (eff_wait <= 16'd1) begin
            ended = 1'b1;
         end else begin
            wait_in = eff_wait - 16'd1;
         end
         if (ended) begin
            step_in = 5'd0;
            hold_in = 16'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 5'd0;
         wait_ff  <= 16'd0;
         hold_ff  <= 16'd0;
         shift_ff <= 8'd0;
      end else if (accept) begin
         step_ff  <= step_in;
         wait_ff  <= wait_in;
         hold_ff  <= hold_in;
         shift_ff <= shift_in;
      end
   end

   assign push_valid                = sample_valid;
   assign push_item.clock_drive_low = drive;
   assign push_item.byte_valid      = ended;
   assign push_item.key_byte        = byte_out;

endmodule

// ===== design/ps2kr_queue.sv =====
// short register queue between the frame receiver and the classifier
// uses ps2kr_pkg for the item type
module ps2kr_queue
   import ps2kr_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  frame_result_type push_item,
   output logic             push_ready,
   output logic             pop_valid,
   output frame_result_type pop_item,
   input  logic             pop_ready
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   frame_result_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_item   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

endmodule

// ===== design/ps2kr_back.sv =====
// key classifier with the result output register
// uses ps2kr_pkg; takes items from ps2kr_queue
module ps2kr_back
   import ps2kr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  pop_valid,
   input  frame_result_type      pop_item,
   output logic                  pop_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   class_state_type cls_ff, cls_in;
   logic [7:0]      prev_ff, prev_in;
   logic [7:0]      repeat_ff, repeat_in;
   logic [7:0]      idle_ff, idle_in;
   press_mode_type  mode_ff, mode_in;
   logic            out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic [7:0]      b;
   logic [7:0]      idle_inc;
   logic [7:0]      repeat_inc;
   logic            take;

   assign b          = pop_item.key_byte;
   assign idle_inc   = idle_ff + 8'd1;
   assign repeat_inc = repeat_ff + 8'd1;
   assign pop_ready  = !out_valid_ff || rsp_tready;
   assign take       = pop_valid && pop_ready;

   always_comb begin
      cls_in    = cls_ff;
      prev_in   = prev_ff;
      repeat_in = repeat_ff;
      idle_in   = idle_ff;
      mode_in   = mode_ff;
      if (pop_item.byte_valid) begin
         if (b == 8'd0) begin
            idle_in = idle_inc;
            if (idle_inc > cfg.idle_limit) begin
               idle_in = 8'd0;
               cls_in  = CLS_IDLE;
            end
         end else begin
            idle_in = 8'd0;
            unique case (cls_ff)
               CLS_PRESSED: begin
                  if (prev_ff == b) begin
                     repeat_in = repeat_inc;
                     if (repeat_inc == cfg.long_press_repeats) begin
                        cls_in    = CLS_LONG;
                        repeat_in = 8'd0;
                        mode_in   = MODE_LONG_BEGUN;
                     end
                  end else if (b == RELEASE_PREFIX) begin
                     prev_in = b;
                  end else begin
                     repeat_in = 8'd0;
                     cls_in    = CLS_IDLE;
                     prev_in   = 8'd0;
                  end
               end
               CLS_LONG: begin
                  if (prev_ff == b) begin
                     mode_in = MODE_LONG_HELD;
                  end else if (b == RELEASE_PREFIX) begin
                     prev_in = b;
                  end else begin
                     mode_in = MODE_NONE;
                     cls_in  = CLS_IDLE;
                  end
               end
               default: begin
                  if (b != RELEASE_PREFIX) begin
                     prev_in = b;
                     cls_in  = CLS_PRESSED;
                     mode_in = MODE_PRESS;
                  end else begin
                     prev_in = 8'd0;
                     mode_in = MODE_NONE;
                     cls_in  = CLS_IDLE;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cls_ff       <= CLS_IDLE;
         prev_ff      <= 8'd0;
         repeat_ff    <= 8'd0;
         idle_ff      <= 8'd0;
         mode_ff      <= MODE_NONE;
         out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            cls_ff    <= cls_in;
            prev_ff   <= prev_in;
            repeat_ff <= repeat_in;
            idle_ff   <= idle_in;
            mode_ff   <= mode_in;
         end
         if (pop_ready) begin
            out_valid_ff <= pop_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_data_ff <= {4'd0, prev_in, mode_in, pop_item.key_byte,
                         pop_item.byte_valid, pop_item.clock_drive_low};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ===== tb/sv/ps2kr_tb_pkg.sv =====
// bit-accurate model of the ps2 key receiver and classifier with a result checker
// one sample in gives one expected rsp item; rsp items are checked in order
// depends on ps2kr_pkg
package ps2kr_tb_pkg;
   import ps2kr_pkg::*;

   typedef struct packed {
      logic           drive_low;
      logic           byte_valid;
      logic [7:0]     key_byte;
      press_mode_type press_mode;
      logic [7:0]     held_code;
   } key_result_type;

   class key_stream_model;
      logic [15:0]     timeout_ticks;
      logic [15:0]     hold_ticks;
      logic [7:0]      long_repeats;
      logic [7:0]      idle_limit;

      logic [4:0]      step;
      logic [15:0]     wait_cnt;
      logic [15:0]     hold_cnt;
      logic [7:0]      shift;
      class_state_type cls;
      logic [7:0]      prev_code;
      logic [7:0]      repeat_cnt;
      logic [7:0]      idle_cnt;
      press_mode_type  mode;

      key_result_type  awaited_outputs[$];
      int              error_count;
      int              samples;
      int              results_checked;
      int              attempts_ended;
      int              timeouts;
      int              long_held_ticks;

      function new();
         timeout_ticks = TIMEOUT_RESET;
         hold_ticks    = HOLD_RESET;
         long_repeats  = REPEATS_RESET;
         idle_limit    = IDLE_RESET;
         step          = '0;
         wait_cnt      = '0;
         hold_cnt      = '0;
         shift         = '0;
         cls           = CLS_IDLE;
         prev_code     = '0;
         repeat_cnt    = '0;
         idle_cnt      = '0;
         mode          = MODE_NONE;
         error_count   = 0;
         samples       = 0;
         results_checked = 0;
         attempts_ended  = 0;
         timeouts        = 0;
         long_held_ticks = 0;
      endfunction

      function void load_reg(csr_index_type idx, logic [15:0] value);
         case (idx)
            CSR_TIMEOUT_TICKS:      timeout_ticks = value;
            CSR_HOLD_TICKS:         hold_ticks    = value;
            CSR_LONG_PRESS_REPEATS: long_repeats  = value[7:0];
            CSR_IDLE_LIMIT:         idle_limit    = value[7:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return awaited_outputs.size();
      endfunction

      function void classify(logic [7:0] code);
         if (code == 8'h00) begin
            idle_cnt = idle_cnt + 8'd1;
            if (idle_cnt > idle_limit) begin
               idle_cnt = '0;
               cls      = CLS_IDLE;
            end
            return;
         end
         idle_cnt = '0;
         case (cls)
            CLS_PRESSED: begin
               if (prev_code == code) begin
                  repeat_cnt = repeat_cnt + 8'd1;
                  if (repeat_cnt == long_repeats) begin
                     cls        = CLS_LONG;
                     repeat_cnt = '0;
                     mode       = MODE_LONG_BEGUN;
                  end
               end else if (code == RELEASE_PREFIX) begin
                  prev_code = code;
               end else begin
                  repeat_cnt = '0;
                  cls        = CLS_IDLE;
                  prev_code  = '0;
               end
            end
            CLS_LONG: begin
               if (prev_code == code) begin
                  mode = MODE_LONG_HELD;
               end else if (code == RELEASE_PREFIX) begin
                  prev_code = code;
               end else begin
                  mode = MODE_NONE;
                  cls  = CLS_IDLE;
               end
            end
            default: begin
               if (code != RELEASE_PREFIX) begin
                  prev_code = code;
                  cls       = CLS_PRESSED;
                  mode      = MODE_PRESS;
               end else begin
                  prev_code = '0;
                  mode      = MODE_NONE;
                  cls       = CLS_IDLE;
               end
            end
         endcase
      endfunction

      function void take_sample(logic clk_l, logic dat_l);
         logic           drive;
         logic           ended;
         logic [7:0]     byte_out;
         logic [4:0]     idx;
         logic           want_low;
         logic           met;
         key_result_type r;
         drive    = 1'b0;
         ended    = 1'b0;
         byte_out = '0;
         samples++;
         if (step == 5'd0 || step > LAST_WAIT) begin
            if (hold_cnt < hold_ticks) begin
               hold_cnt = hold_cnt + 16'd1;
               drive    = 1'b1;
            end else begin
               hold_cnt = '0;
               step     = 5'd1;
               wait_cnt = timeout_ticks;
            end
         end
         if (!drive) begin
            idx      = step - 5'd1;
            want_low = !idx[0];
            met      = want_low ? !clk_l : clk_l;
            if (met) begin
               if (want_low && idx >= 5'd2 && idx <= 5'd16)
                  shift = {dat_l, shift[7:1]};
               if (step >= LAST_WAIT) begin
                  ended    = 1'b1;
                  byte_out = shift;
               end else begin
                  step     = step + 5'd1;
                  wait_cnt = timeout_ticks;
               end
            end else if (wait_cnt <= 16'd1) begin
               ended    = 1'b1;
               byte_out = '0;
               timeouts++;
            end else begin
               wait_cnt = wait_cnt - 16'd1;
            end
            if (ended) begin
               step     = '0;
               hold_cnt = '0;
               attempts_ended++;
               classify(byte_out);
            end
         end
         if (mode == MODE_LONG_HELD)
            long_held_ticks++;
         r.drive_low  = drive;
         r.byte_valid = ended;
         r.key_byte   = byte_out;
         r.press_mode = mode;
         r.held_code  = prev_code;
         awaited_outputs.push_back(r);
      endfunction

      function void match_result(logic [23:0] d);
         key_result_type exp_r;
         if (awaited_outputs.size() == 0) begin
            $error("rsp item with nothing expected: %06h", d);
            error_count++;
            return;
         end
         exp_r = awaited_outputs.pop_front();
         results_checked++;
         if (d[0] !== exp_r.drive_low) begin
            $error("clock_drive_low expected %0h got %0h", exp_r.drive_low, d[0]);
            error_count++;
         end
         if (d[1] !== exp_r.byte_valid) begin
            $error("byte_valid expected %0h got %0h", exp_r.byte_valid, d[1]);
            error_count++;
         end
         if (d[9:2] !== exp_r.key_byte) begin
            $error("key_byte expected %02h got %02h", exp_r.key_byte, d[9:2]);
            error_count++;
         end
         if (d[11:10] !== exp_r.press_mode) begin
            $error("press_mode expected %0d got %0d", exp_r.press_mode, d[11:10]);
            error_count++;
         end
         if (d[19:12] !== exp_r.held_code) begin
            $error("held_code expected %02h got %02h", exp_r.held_code, d[19:12]);
            error_count++;
         end
      endfunction
   endclass

endpackage

// ===== tb/sv/tb_ps2_key_receiver_classifier_unit.sv =====
// top-level testbench for ps2_key_receiver_classifier_unit
// drives ps2 line samples and register writes, checks every rsp item against the model
// depends on ps2kr_pkg, ps2kr_tb_pkg and the unit under test
module tb_ps2_key_receiver_classifier_unit;
   import ps2kr_pkg::*;
   import ps2kr_tb_pkg::*;

   typedef enum {FRAME_CLEAN, FRAME_ABORT, FRAME_NOISE} frame_kind_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;  // [0] clock_level, [1] data_level
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [0] clock_drive_low, [1] byte_valid, [9:2] key_byte, [11:10] press_mode,
   // [19:12] held_code
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [1:0]            csr_addr;
   logic [15:0]           csr_wdata;

   logic                  idle_enable;
   logic                  hold_off_req;

   key_stream_model       model;

   frame_kind_type        plan_kind;
   logic [7:0]            plan_code;
   logic [7:0]            last_code;
   logic [4:0]            plan_abort_at;
   logic                  plan_ready;

   ps2_key_receiver_classifier_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #400_000;
      $display("Regression FAIL");
      $finish;
   end

   initial model = new();

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         model.match_result(rsp_tdata);
   end

   // receiver side: random stalls, plus one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready   = 1'b0;
            repeat (80) @(negedge clock);
         end
         rsp_tready = !idle_enable || ($urandom_range(99) >= 11);
      end
   end

   task automatic send_sample(input logic clk_l, input logic dat_l);
      @(negedge clock);
      while (idle_enable && $urandom_range(99) < 11) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {6'b0, dat_l, clk_l};
      do @(posedge clock); while (!req_tready);
      model.take_sample(clk_l, dat_l);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (model.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_addr  = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      model.load_reg(idx, value);
   endtask

   task automatic program_regs(input logic [15:0] tmo, input logic [15:0] hold,
                               input logic [15:0] reps, input logic [15:0] idl);
      write_reg(CSR_TIMEOUT_TICKS, tmo);
      write_reg(CSR_HOLD_TICKS, hold);
      write_reg(CSR_LONG_PRESS_REPEATS, reps);
      write_reg(CSR_IDLE_LIMIT, idl);
   endtask

   task automatic new_plan();
      int r;
      int k;
      r = $urandom_range(99);
      if (r < 35)      plan_code = last_code;
      else if (r < 50) plan_code = RELEASE_PREFIX;
      else if (r < 58) plan_code = 8'h00;
      else if (r < 66) plan_code = 8'h1c;
      else if (r < 75) plan_code = 8'h5a;
      else             plan_code = 8'($urandom);
      last_code = plan_code;
      k = $urandom_range(99);
      plan_abort_at = 5'($urandom_range(21));
      if (model.timeout_ticks > 16'd16 || k < 75) plan_kind = FRAME_CLEAN;
      else if (k < 88)                           plan_kind = FRAME_ABORT;
      else                                       plan_kind = FRAME_NOISE;
   endtask

   // picks line levels for the next tick from the predicted receiver state
   task automatic next_levels(output logic clk_l, output logic dat_l);
      logic [4:0]  idx;
      logic [15:0] budget;
      logic        want_low;
      logic        fail;
      if (model.step == 5'd0 || model.step > LAST_WAIT) begin
         if (!plan_ready) new_plan();
         plan_ready = 1'b1;
         if (model.hold_cnt < model.hold_ticks) begin
            clk_l = 1'($urandom);
            dat_l = 1'($urandom);
            return;
         end
         idx    = 5'd0;
         budget = model.timeout_ticks;
      end else begin
         plan_ready = 1'b0;
         idx        = model.step - 5'd1;
         budget     = model.wait_cnt;
      end
      want_low = !idx[0];
      if (want_low && idx >= 5'd2 && idx <= 5'd16)
         dat_l = plan_code[(idx - 5'd2) >> 1];
      else
         dat_l = 1'($urandom);
      case (plan_kind)
         FRAME_ABORT: fail = (idx >= plan_abort_at);
         FRAME_NOISE: fail = 1'($urandom);
         default:     fail = (budget > 16'd1) && ($urandom_range(99) < 15);
      endcase
      clk_l = want_low ? fail : !fail;
   endtask

   task automatic run_ticks(input int n);
      logic c;
      logic d;
      repeat (n) begin
         next_levels(c, d);
         send_sample(c, d);
      end
   endtask

   // clean frame with no hold before it; random start, parity and stop levels
   task automatic send_frame(input logic [7:0] code);
      logic d;
      while (model.step != 5'd0) send_sample(1'($urandom), 1'($urandom));
      for (int i = 0; i < 22; i++) begin
         if (i % 2 == 0 && i >= 2 && i <= 16) d = code[(i - 2) / 2];
         else                                  d = 1'($urandom);
         send_sample(i[0], d);
      end
   endtask

   initial begin : stimulus
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      csr_we        = 1'b0;
      csr_addr      = CSR_TIMEOUT_TICKS;
      csr_wdata     = '0;
      idle_enable   = 1'b1;
      hold_off_req  = 1'b0;
      plan_ready    = 1'b0;
      plan_kind     = FRAME_CLEAN;
      plan_code     = '0;
      plan_abort_at = '0;
      last_code     = 8'h1c;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // register defaults straight out of reset
      run_ticks(40);
      drain();

      // directed frames: press, long press, long held, release prefix, zero byte
      program_regs(16'd2, 16'd0, 16'd1, 16'd0);
      send_frame(8'hff);
      send_frame(8'hff);
      send_frame(8'hff);
      send_frame(RELEASE_PREFIX);
      send_frame(8'hff);
      send_frame(8'h00);
      send_frame(8'h12);
      send_frame(RELEASE_PREFIX);
      send_sample(1'b1, 1'b0);
      send_sample(1'b1, 1'b1);
      drain();

      for (int p = 0; p < 6; p++) begin
         program_regs((p == 0) ? 16'd1 : 16'($urandom_range(2, 12)),
                      (p == 0) ? 16'd0 : 16'($urandom_range(0, 5)),
                      {8'($urandom), 8'($urandom_range(1, 4))},
                      {8'($urandom), 8'($urandom_range(0, 3))});
         idle_enable = (p != 2);
         if (p == 3) hold_off_req = 1'b1;
         run_ticks(130);
         drain();
      end
      idle_enable = 1'b1;

      // zero timeout, idle count wrapping past 255
      program_regs(16'd0, 16'd0, 16'hff00, 16'hffff);
      repeat (300) send_sample(1'b1, 1'($urandom));
      drain();

      // largest timeout and hold
      program_regs(16'hffff, 16'hffff, 16'h00ff, 16'h00fe);
      run_ticks(40);
      drain();

      repeat (10) @(posedge clock);
      $display("covered %0d samples, %0d attempts ended, %0d of them by timeout",
               model.samples, model.attempts_ended, model.timeouts);
      $display("%0d rsp items checked, %0d ticks in long-held mode",
               model.results_checked, model.long_held_ticks);
      if (model.error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
